>>> hdl/evr_pkg.sv
// Shared types, constants and sine/cosine tables for the Euler vertex rotation block.
package evr_pkg;

   // Field widths and fixed-point formats.
   localparam int COORD_WIDTH    = 32;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int ANGLE_W        = 9;
   localparam int CSR_INDEX_W    = 2;
   localparam int NUM_COORDS     = 3;
   localparam int NUM_ENTRIES    = NUM_COORDS * NUM_COORDS;
   localparam int VERTEX_W       = NUM_COORDS * COORD_WIDTH;
   localparam int TDATA_W        = ((VERTEX_W + 7) / 8) * 8;

   // Angle constants in whole degrees.
   localparam int FULL_TURN    = 360;
   localparam int QUARTER_DEG  = 90;
   localparam int OCTANT_DEG   = 45;
   localparam int QUARTER_IDX_W = $clog2(QUARTER_DEG);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_FIRST  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_SECOND = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_THIRD  = CSR_INDEX_W'(2);

   // Constants of the Q2.30 series evaluation.
   localparam longint PI_Q30    = 64'sd3373259426;
   localparam longint ONE_Q30   = 64'sd1073741824;
   localparam longint HALF_Q30  = 64'sd536870912;
   localparam int     TRIG_SHIFT = 30 - TRIG_FRAC_BITS;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef coord_type                     vertex_type [NUM_COORDS];
   typedef logic signed [TRIG_W-1:0]      trig_type;
   typedef trig_type                      matrix_type [NUM_ENTRIES];
   typedef trig_type                      trig_table_type [QUARTER_DEG];
   typedef logic [ANGLE_W-1:0]            angle_type;

   localparam trig_type TRIG_ONE = trig_type'(1 << TRIG_FRAC_BITS);

   // Request from the register file to the matrix builder.
   typedef struct packed {
      logic      start;
      angle_type angle_first;
      angle_type angle_second;
      angle_type angle_third;
   } build_req_type;

   // Sine and cosine of one angle.
   typedef struct packed {
      trig_type sin_v;
      trig_type cos_v;
   } sincos_type;

   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } quadrant_type;

   typedef enum logic [1:0] {
      BUILD_IDLE,
      BUILD_LOOKUP,
      BUILD_MUL,
      BUILD_SUM
   } build_state_type;

   // Rounded Q2.30 product.
   function automatic longint mul_round30(input longint a, input longint b);
      return (a * b + HALF_Q30) >>> 30;
   endfunction

   // Taylor series of sine or cosine for an angle of 0 to 45 degrees, in Q2.30.
   function automatic longint trig_series(input int r, input bit want_cos);
      longint x;
      longint x2;
      longint ts;
      longint s;
      longint tc;
      longint c;
      x  = (longint'(r) * PI_Q30 + 64'sd90) / 64'sd180;
      x2 = mul_round30(x, x);
      ts = x;
      s  = x;
      tc = ONE_Q30;
      c  = ONE_Q30;
      // Sine terms up to x^13; each divisor is (2n)(2n+1).
      ts = -mul_round30(ts, x2) / 64'sd6;
      s  = s + ts;
      ts = -mul_round30(ts, x2) / 64'sd20;
      s  = s + ts;
      ts = -mul_round30(ts, x2) / 64'sd42;
      s  = s + ts;
      ts = -mul_round30(ts, x2) / 64'sd72;
      s  = s + ts;
      ts = -mul_round30(ts, x2) / 64'sd110;
      s  = s + ts;
      ts = -mul_round30(ts, x2) / 64'sd156;
      s  = s + ts;
      // Cosine terms up to x^12; each divisor is (2n-1)(2n).
      tc = -mul_round30(tc, x2) / 64'sd2;
      c  = c + tc;
      tc = -mul_round30(tc, x2) / 64'sd12;
      c  = c + tc;
      tc = -mul_round30(tc, x2) / 64'sd30;
      c  = c + tc;
      tc = -mul_round30(tc, x2) / 64'sd56;
      c  = c + tc;
      tc = -mul_round30(tc, x2) / 64'sd90;
      c  = c + tc;
      tc = -mul_round30(tc, x2) / 64'sd132;
      c  = c + tc;
      return want_cos ? c : s;
   endfunction

   // Round a Q2.30 value half up to the trig format.
   function automatic trig_type trig_round(input longint v);
      if (TRIG_SHIFT == 0) begin
         return trig_type'(v);
      end
      return trig_type'((v + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT);
   endfunction

   // Quarter-wave table, optionally negated before the rounding.
   function automatic trig_table_type make_trig_table(input bit want_cos, input bit negate);
      trig_table_type t;
      longint         v;
      int             r;
      for (r = 0; r < QUARTER_DEG; r++) begin
         if (r <= OCTANT_DEG) begin
            v = trig_series(r, want_cos);
         end else begin
            v = trig_series(QUARTER_DEG - r, !want_cos);
         end
         if (negate) begin
            v = -v;
         end
         t[r] = trig_round(v);
      end
      return t;
   endfunction

   localparam trig_table_type SIN_POS_TABLE = make_trig_table(1'b0, 1'b0);
   localparam trig_table_type SIN_NEG_TABLE = make_trig_table(1'b0, 1'b1);
   localparam trig_table_type COS_POS_TABLE = make_trig_table(1'b1, 1'b0);
   localparam trig_table_type COS_NEG_TABLE = make_trig_table(1'b1, 1'b1);

endpackage

>>> hdl/evr_matrix_build.sv
// Sequencer that builds the rotation matrix from the three angles with one shared multiplier.
module evr_matrix_build
   import evr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  build_req_type build_req,
   output logic          build_busy,
   output matrix_type    matrix
);

   localparam int PROD_W = TRIG_W + 2;
   localparam int SUM_W  = PROD_W + 1;
   localparam int N_PROD = 14;
   localparam int STEP_W = $clog2(N_PROD);

   // Product slots, in the order the shared multiplier computes them.
   localparam logic [STEP_W-1:0] P_AB    = STEP_W'(0);
   localparam logic [STEP_W-1:0] P_SAB   = STEP_W'(1);
   localparam logic [STEP_W-1:0] P_CACB  = STEP_W'(2);
   localparam logic [STEP_W-1:0] P_ABSC  = STEP_W'(3);
   localparam logic [STEP_W-1:0] P_SACC  = STEP_W'(4);
   localparam logic [STEP_W-1:0] P_ABCC  = STEP_W'(5);
   localparam logic [STEP_W-1:0] P_SASC  = STEP_W'(6);
   localparam logic [STEP_W-1:0] P_SACB  = STEP_W'(7);
   localparam logic [STEP_W-1:0] P_SABSC = STEP_W'(8);
   localparam logic [STEP_W-1:0] P_CACC  = STEP_W'(9);
   localparam logic [STEP_W-1:0] P_SABCC = STEP_W'(10);
   localparam logic [STEP_W-1:0] P_CASC  = STEP_W'(11);
   localparam logic [STEP_W-1:0] P_CBSC  = STEP_W'(12);
   localparam logic [STEP_W-1:0] P_CBCC  = STEP_W'(13);
   localparam logic [STEP_W-1:0] P_LAST  = STEP_W'(N_PROD - 1);

   localparam logic signed [2*PROD_W-1:0] MUL_HALF =
      (2*PROD_W)'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] ENTRY_MAX =
      SUM_W'((1 << (TRIG_FRAC_BITS + 1)) - 1);
   localparam logic signed [SUM_W-1:0] ENTRY_MIN = ~ENTRY_MAX;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   build_state_type   state_ff;
   build_state_type   state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   sincos_type        first_ff;
   sincos_type        second_ff;
   sincos_type        third_ff;
   prod_type          prod_ff [N_PROD];
   prod_type          mul_res_in;
   matrix_type        matrix_ff;
   matrix_type        matrix_in;
   logic              lookup_en;
   logic              mul_en;
   logic              sum_en;
   prod_type          op_a;
   prod_type          op_b;
   logic signed [2*PROD_W-1:0] mul_full;
   logic signed [2*PROD_W-1:0] mul_rnd;

   // Reduce an angle to a quadrant and a table index, then pick the table entries.
   function automatic sincos_type angle_lookup(input angle_type a);
      angle_type                d;
      quadrant_type             q;
      logic [QUARTER_IDX_W-1:0] r;
      sincos_type               sc;
      d = (a >= ANGLE_W'(FULL_TURN)) ? a - ANGLE_W'(FULL_TURN) : a;
      if (d >= ANGLE_W'(3 * QUARTER_DEG)) begin
         q = QUAD_FOURTH;
         r = QUARTER_IDX_W'(d - ANGLE_W'(3 * QUARTER_DEG));
      end else if (d >= ANGLE_W'(2 * QUARTER_DEG)) begin
         q = QUAD_THIRD;
         r = QUARTER_IDX_W'(d - ANGLE_W'(2 * QUARTER_DEG));
      end else if (d >= ANGLE_W'(QUARTER_DEG)) begin
         q = QUAD_SECOND;
         r = QUARTER_IDX_W'(d - ANGLE_W'(QUARTER_DEG));
      end else begin
         q = QUAD_FIRST;
         r = QUARTER_IDX_W'(d);
      end
      case (q)
         QUAD_SECOND: begin
            sc.sin_v = COS_POS_TABLE[r];
            sc.cos_v = SIN_NEG_TABLE[r];
         end
         QUAD_THIRD: begin
            sc.sin_v = SIN_NEG_TABLE[r];
            sc.cos_v = COS_NEG_TABLE[r];
         end
         QUAD_FOURTH: begin
            sc.sin_v = COS_NEG_TABLE[r];
            sc.cos_v = SIN_POS_TABLE[r];
         end
         default: begin
            sc.sin_v = SIN_POS_TABLE[r];
            sc.cos_v = COS_POS_TABLE[r];
         end
      endcase
      return sc;
   endfunction

   // Saturate a matrix entry to the trig format.
   function automatic trig_type sat_entry(input sum_type v);
      if (v > ENTRY_MAX) begin
         return ENTRY_MAX[TRIG_W-1:0];
      end
      if (v < ENTRY_MIN) begin
         return ENTRY_MIN[TRIG_W-1:0];
      end
      return v[TRIG_W-1:0];
   endfunction

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BUILD_IDLE: begin
            if (build_req.start) begin
               state_in = BUILD_LOOKUP;
            end
         end
         BUILD_LOOKUP: state_in = BUILD_MUL;
         BUILD_MUL: begin
            if (step_ff == P_LAST) begin
               state_in = BUILD_SUM;
            end
         end
         BUILD_SUM: state_in = BUILD_IDLE;
         default:   state_in = BUILD_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      build_busy = 1'b1;
      lookup_en  = 1'b0;
      mul_en     = 1'b0;
      sum_en     = 1'b0;
      case (state_ff)
         BUILD_IDLE:   build_busy = 1'b0;
         BUILD_LOOKUP: lookup_en  = 1'b1;
         BUILD_MUL:    mul_en     = 1'b1;
         BUILD_SUM:    sum_en     = 1'b1;
         default:      build_busy = 1'b1;
      endcase
   end

   // The step counter runs over the product slots.
   always_comb begin
      step_in = step_ff;
      if (lookup_en) begin
         step_in = '0;
      end else if (mul_en && (step_ff != P_LAST)) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = prod_type'(first_ff.cos_v);
      op_b = prod_type'(first_ff.cos_v);
      case (step_ff)
         P_AB:    begin op_a = prod_type'(first_ff.cos_v);  op_b = prod_type'(second_ff.sin_v); end
         P_SAB:   begin op_a = prod_type'(first_ff.sin_v);  op_b = prod_type'(second_ff.sin_v); end
         P_CACB:  begin op_a = prod_type'(first_ff.cos_v);  op_b = prod_type'(second_ff.cos_v); end
         P_ABSC:  begin op_a = prod_ff[P_AB];               op_b = prod_type'(third_ff.sin_v);  end
         P_SACC:  begin op_a = prod_type'(first_ff.sin_v);  op_b = prod_type'(third_ff.cos_v);  end
         P_ABCC:  begin op_a = prod_ff[P_AB];               op_b = prod_type'(third_ff.cos_v);  end
         P_SASC:  begin op_a = prod_type'(first_ff.sin_v);  op_b = prod_type'(third_ff.sin_v);  end
         P_SACB:  begin op_a = prod_type'(first_ff.sin_v);  op_b = prod_type'(second_ff.cos_v); end
         P_SABSC: begin op_a = prod_ff[P_SAB];              op_b = prod_type'(third_ff.sin_v);  end
         P_CACC:  begin op_a = prod_type'(first_ff.cos_v);  op_b = prod_type'(third_ff.cos_v);  end
         P_SABCC: begin op_a = prod_ff[P_SAB];              op_b = prod_type'(third_ff.cos_v);  end
         P_CASC:  begin op_a = prod_type'(first_ff.cos_v);  op_b = prod_type'(third_ff.sin_v);  end
         P_CBSC:  begin op_a = prod_type'(second_ff.cos_v); op_b = prod_type'(third_ff.sin_v);  end
         P_CBCC:  begin op_a = prod_type'(second_ff.cos_v); op_b = prod_type'(third_ff.cos_v);  end
         default: begin op_a = prod_type'(first_ff.cos_v);  op_b = prod_type'(first_ff.cos_v);  end
      endcase
   end

   // Rounded product in the trig format.
   always_comb begin
      mul_full   = (2*PROD_W)'(op_a) * (2*PROD_W)'(op_b);
      mul_rnd    = (mul_full + MUL_HALF) >>> TRIG_FRAC_BITS;
      mul_res_in = mul_rnd[PROD_W-1:0];
   end

   // Combine the products into the nine saturated entries.
   always_comb begin
      matrix_in[0] = sat_entry(sum_type'(prod_ff[P_CACB]));
      matrix_in[1] = sat_entry(sum_type'(prod_ff[P_ABSC]) - sum_type'(prod_ff[P_SACC]));
      matrix_in[2] = sat_entry(sum_type'(prod_ff[P_ABCC]) + sum_type'(prod_ff[P_SASC]));
      matrix_in[3] = sat_entry(sum_type'(prod_ff[P_SACB]));
      matrix_in[4] = sat_entry(sum_type'(prod_ff[P_SABSC]) + sum_type'(prod_ff[P_CACC]));
      matrix_in[5] = sat_entry(sum_type'(prod_ff[P_SABCC]) - sum_type'(prod_ff[P_CASC]));
      matrix_in[6] = sat_entry(-sum_type'(second_ff.sin_v));
      matrix_in[7] = sat_entry(sum_type'(prod_ff[P_CBSC]));
      matrix_in[8] = sat_entry(sum_type'(prod_ff[P_CBCC]));
   end

   // Sequencer state and matrix registers; the matrix resets to identity.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BUILD_IDLE;
         step_ff  <= '0;
         for (int row = 0; row < NUM_COORDS; row++) begin
            for (int col = 0; col < NUM_COORDS; col++) begin
               matrix_ff[row * NUM_COORDS + col] <= (row == col) ? TRIG_ONE : '0;
            end
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (sum_en) begin
            matrix_ff <= matrix_in;
         end
      end
   end

   // Working registers of the build.
   always_ff @(posedge clock) begin
      if (lookup_en) begin
         first_ff  <= angle_lookup(build_req.angle_first);
         second_ff <= angle_lookup(build_req.angle_second);
         third_ff  <= angle_lookup(build_req.angle_third);
      end
      if (mul_en) begin
         prod_ff[step_ff] <= mul_res_in;
      end
   end

   assign matrix = matrix_ff;

   // A rebuild only starts while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      build_req.start |-> (state_ff == BUILD_IDLE))
      else $error("matrix build started while a rebuild was running");

   // The product phase always starts at the first slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BUILD_LOOKUP) |=> (state_ff == BUILD_MUL) && (step_ff == P_AB))
      else $error("matrix build entered the product phase at a wrong slot");

   // After the last product the entries are combined in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BUILD_MUL) && (step_ff == P_LAST) |=> (state_ff == BUILD_SUM))
      else $error("matrix build did not finish after the last product");

endmodule

>>> hdl/evr_vertex_pipe.sv
// Three-stage multiply, sum, saturate pipeline: one vertex per clock unless held.
module evr_vertex_pipe
   import evr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  vertex_type coord,
   input  logic       build_busy,
   input  matrix_type matrix,
   output logic       out_valid,
   input  logic       out_ready,
   output vertex_type rot
);

   localparam int P1_W  = COORD_WIDTH + TRIG_W;
   localparam int S_W   = P1_W + 2;

   localparam logic signed [S_W-1:0] ROUND_HALF = S_W'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [S_W-1:0] MAX_POS =
      {{(S_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [S_W-1:0] MIN_NEG = ~MAX_POS;

   typedef logic signed [P1_W-1:0] prod_type;
   typedef logic signed [S_W-1:0]  sum_type;

   logic       v1_ff;
   logic       v1_in;
   logic       v2_ff;
   logic       v2_in;
   logic       v3_ff;
   logic       v3_in;
   logic       en1;
   logic       en2;
   logic       en3;
   logic       accept;
   prod_type   prod1_ff [NUM_ENTRIES];
   prod_type   prod1_in [NUM_ENTRIES];
   sum_type    sum2_ff [NUM_COORDS];
   sum_type    sum2_in [NUM_COORDS];
   vertex_type out3_ff;
   vertex_type out3_in;

   // Each stage moves when it is empty or the stage after it moves.
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1 && !build_busy;
   assign accept   = in_valid && in_ready;

   // Valid bits follow the data through the stages.
   always_comb begin
      v1_in = en1 ? accept : v1_ff;
      v2_in = en2 ? v1_ff  : v2_ff;
      v3_in = en3 ? v2_ff  : v3_ff;
   end

   // Stage one: the nine coordinate times entry products.
   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) begin
         for (int j = 0; j < NUM_COORDS; j++) begin
            prod1_in[i * NUM_COORDS + j] =
               prod_type'(coord[j]) * prod_type'(matrix[i * NUM_COORDS + j]);
         end
      end
   end

   // Stage two: exact row sums with the rounding half added.
   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) begin
         sum2_in[i] = sum_type'(prod1_ff[i * NUM_COORDS])
                    + sum_type'(prod1_ff[i * NUM_COORDS + 1])
                    + sum_type'(prod1_ff[i * NUM_COORDS + 2])
                    + ROUND_HALF;
      end
   end

   // Stage three: drop the fraction bits and saturate to the coordinate width.
   always_comb begin
      sum_type shifted;
      for (int i = 0; i < NUM_COORDS; i++) begin
         shifted = sum2_ff[i] >>> TRIG_FRAC_BITS;
         if (shifted > MAX_POS) begin
            out3_in[i] = MAX_POS[COORD_WIDTH-1:0];
         end else if (shifted < MIN_NEG) begin
            out3_in[i] = MIN_NEG[COORD_WIDTH-1:0];
         end else begin
            out3_in[i] = shifted[COORD_WIDTH-1:0];
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Payload registers load only when their stage moves.
   always_ff @(posedge clock) begin
      if (en1) begin
         prod1_ff <= prod1_in;
      end
      if (en2) begin
         sum2_ff <= sum2_in;
      end
      if (en3) begin
         out3_ff <= out3_in;
      end
   end

   assign out_valid = v3_ff;
   assign rot       = out3_ff;

   // No vertex enters while the matrix is being rebuilt.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |-> !build_busy)
      else $error("vertex accepted during a matrix rebuild");

   // A held middle stage keeps its item and its first row sum.
   assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en3) |=> v2_ff && $stable(sum2_ff[0]))
      else $error("stalled middle stage lost or changed its item");

   // Once the output drains with nothing behind it, no result appears.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && !v2_ff) |=> !out_valid)
      else $error("result appeared without an item behind it");

endmodule

>>> hdl/euler_vertex_rotate_core.sv
// Top level of the Euler vertex rotation block: register file, matrix builder and pipeline.
//
// Usage: the three angles (degrees, 9 bits each, taken modulo 360) are written over the
// csr channel with index 0 for the z rotation, 1 for y and 2 for x; other indexes are
// ignored. Each write rebuilds the matrix: one table lookup, fourteen products on the
// shared 18x18 multiplier, one combine. While the rebuild runs, req_tready and csr_ready
// are low. Write the angles only while no vertex is in flight. Vertices enter on the req
// channel as three signed Q16.16 coordinates and leave on the rsp channel rotated,
// rounded and saturated to 32 bits, in the same order. An accepted req transaction
// goes through the three registered stages (products, row sums, saturation) to rsp_tvalid.
// Throughput is one vertex per cycle while rsp_tready is high and no rebuild runs. When
// the receiver holds rsp_tready low, each stage keeps its item and empty stages still
// fill, so up to three vertices are held; nothing is dropped or repeated.
// Reset clears the angles to zero and the matrix to identity; the pipeline is empty.
module euler_vertex_rotate_core
   import evr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input vertices.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W-1:0]     req_tdata,   // coord_x, coord_y, coord_z
   // Rotated vertices.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_W-1:0]     rsp_tdata,   // rot_x, rot_y, rot_z
   // Angle register writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ANGLE_W-1:0]     csr_wdata
);

   angle_type     angle_first_ff;
   angle_type     angle_first_in;
   angle_type     angle_second_ff;
   angle_type     angle_second_in;
   angle_type     angle_third_ff;
   angle_type     angle_third_in;
   logic          angle_write;
   logic          build_busy;
   build_req_type build_req;
   matrix_type    matrix;
   vertex_type    coord;
   vertex_type    rot;

   assign csr_ready = !build_busy;

   // Decode a register write transaction.
   always_comb begin
      angle_first_in  = angle_first_ff;
      angle_second_in = angle_second_ff;
      angle_third_in  = angle_third_ff;
      angle_write     = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANGLE_FIRST: begin
               angle_first_in = csr_wdata;
               angle_write    = 1'b1;
            end
            CSR_ANGLE_SECOND: begin
               angle_second_in = csr_wdata;
               angle_write     = 1'b1;
            end
            CSR_ANGLE_THIRD: begin
               angle_third_in = csr_wdata;
               angle_write    = 1'b1;
            end
            default: angle_write = 1'b0;
         endcase
      end
   end

   // Angle registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_first_ff  <= '0;
         angle_second_ff <= '0;
         angle_third_ff  <= '0;
      end else begin
         angle_first_ff  <= angle_first_in;
         angle_second_ff <= angle_second_in;
         angle_third_ff  <= angle_third_in;
      end
   end

   always_comb begin
      build_req.start        = angle_write;
      build_req.angle_first  = angle_first_ff;
      build_req.angle_second = angle_second_ff;
      build_req.angle_third  = angle_third_ff;
   end

   // Unpack the input vertex and pack the result, padding with zeros.
   always_comb begin
      rsp_tdata = '0;
      for (int j = 0; j < NUM_COORDS; j++) begin
         coord[j] = req_tdata[j * COORD_WIDTH +: COORD_WIDTH];
         rsp_tdata[j * COORD_WIDTH +: COORD_WIDTH] = rot[j];
      end
   end

   evr_matrix_build u_build (
      .clock      (clock),
      .reset      (reset),
      .build_req  (build_req),
      .build_busy (build_busy),
      .matrix     (matrix)
   );

   evr_vertex_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .coord      (coord),
      .build_busy (build_busy),
      .matrix     (matrix),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .rot        (rot)
   );

endmodule

>>> tb/tb_euler_vertex_rotate_core.sv
// Self-checking testbench for the Euler vertex rotation core, with a bit-exact matrix predictor.
`timescale 1ns / 100ps

module tb_euler_vertex_rotate_core;
   import evr_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int PIPE_LATENCY  = 3;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PRINT_LIMIT   = 30;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int ANGLE_MAX     = (1 << ANGLE_W) - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_INDEX_W'(3);

   localparam longint TRIG_HALF = 64'sd1 <<< (TRIG_FRAC_BITS - 1);
   localparam longint ENTRY_MAX = (64'sd1 <<< (TRIG_FRAC_BITS + 1)) - 64'sd1;
   localparam longint ENTRY_MIN = -(64'sd1 <<< (TRIG_FRAC_BITS + 1));
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   // One vertex as it sits in tdata: x in the lowest bits.
   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata  = '0;   // coord_x, coord_y, coord_z
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;         // rot_x, rot_y, rot_z
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [ANGLE_W-1:0]     csr_wdata  = '0;

   // Predictor state: the angles as written and the matrix built from them.
   angle_type angle_z_deg;
   angle_type angle_y_deg;
   angle_type angle_x_deg;
   longint    rot_matrix [NUM_ENTRIES];

   point_t pending_rotations [$];
   point_t got_point;
   point_t want_point;
   int     mismatches  = 0;
   int     idle_cycles = 0;
   int     cycle_no    = 0;
   int     stall_left  = 0;
   int     burst_left  = 0;

   euler_vertex_rotate_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // Rounded product of two Q2.30 values.
   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + HALF_Q30) >>> 30;
   endfunction

   // Rounded product of two trig-format values.
   function automatic longint fmul(input longint a, input longint b);
      return (a * b + TRIG_HALF) >>> TRIG_FRAC_BITS;
   endfunction

   // Round a Q2.30 value half up to the trig format.
   function automatic longint trig_q(input longint v);
      return (v + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
   endfunction

   // Sine and cosine of 0 to 45 degrees by Taylor series, in Q2.30.
   function automatic void taylor_q30(input int deg, output longint s, output longint c);
      longint x;
      longint x2;
      longint ts;
      longint tc;
      int     n;
      x  = (longint'(deg) * PI_Q30 + 64'sd90) / 64'sd180;
      x2 = q30_mul(x, x);
      ts = x;
      s  = x;
      tc = ONE_Q30;
      c  = ONE_Q30;
      for (n = 1; n <= 6; n++) begin
         ts = -q30_mul(ts, x2) / longint'((2 * n) * (2 * n + 1));
         s  = s + ts;
         tc = -q30_mul(tc, x2) / longint'((2 * n - 1) * (2 * n));
         c  = c + tc;
      end
   endfunction

   // Sine and cosine of any register value, reduced modulo a full turn.
   function automatic void angle_trig(input angle_type deg, output longint s_q,
                                      output longint c_q);
      int           d;
      int           r;
      quadrant_type quad;
      longint       s;
      longint       c;
      longint       t;
      d    = int'(deg) % FULL_TURN;
      quad = quadrant_type'(d / QUARTER_DEG);
      r    = d % QUARTER_DEG;
      if (r <= OCTANT_DEG) begin
         taylor_q30(r, s, c);
      end else begin
         taylor_q30(QUARTER_DEG - r, c, s);
      end
      case (quad)
         QUAD_SECOND: begin
            t = s;
            s = c;
            c = -t;
         end
         QUAD_THIRD: begin
            s = -s;
            c = -c;
         end
         QUAD_FOURTH: begin
            t = s;
            s = -c;
            c = t;
         end
         default: begin
         end
      endcase
      s_q = trig_q(s);
      c_q = trig_q(c);
   endfunction

   // Z-Y-X rotation matrix from the three angles, entries clamped to the trig format.
   function automatic void rebuild_matrix();
      longint sa, ca, sb, cb, sc, cc, ab, sab;
      int     i;
      angle_trig(angle_z_deg, sa, ca);
      angle_trig(angle_y_deg, sb, cb);
      angle_trig(angle_x_deg, sc, cc);
      ab  = fmul(ca, sb);
      sab = fmul(sa, sb);
      rot_matrix[0] = fmul(ca, cb);
      rot_matrix[1] = fmul(ab, sc) - fmul(sa, cc);
      rot_matrix[2] = fmul(ab, cc) + fmul(sa, sc);
      rot_matrix[3] = fmul(sa, cb);
      rot_matrix[4] = fmul(sab, sc) + fmul(ca, cc);
      rot_matrix[5] = fmul(sab, cc) - fmul(ca, sc);
      rot_matrix[6] = -sb;
      rot_matrix[7] = fmul(cb, sc);
      rot_matrix[8] = fmul(cb, cc);
      for (i = 0; i < NUM_ENTRIES; i++) begin
         if (rot_matrix[i] > ENTRY_MAX) begin
            rot_matrix[i] = ENTRY_MAX;
         end else if (rot_matrix[i] < ENTRY_MIN) begin
            rot_matrix[i] = ENTRY_MIN;
         end
      end
   endfunction

   // One output coordinate: exact dot product, rounded and saturated.
   function automatic coord_type rotate_row(input point_t p, input int row);
      longint acc;
      acc = longint'(p.x) * rot_matrix[row * 3]
          + longint'(p.y) * rot_matrix[row * 3 + 1]
          + longint'(p.z) * rot_matrix[row * 3 + 2];
      acc = (acc + TRIG_HALF) >>> TRIG_FRAC_BITS;
      if (acc > longint'(COORD_MAX)) begin
         return COORD_MAX;
      end
      if (acc < longint'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return coord_type'(acc);
   endfunction

   function automatic point_t rotate_vertex(input point_t p);
      point_t r;
      r.x = rotate_row(p, 0);
      r.y = rotate_row(p, 1);
      r.z = rotate_row(p, 2);
      return r;
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return coord_type'(int'($urandom_range(0, 2)) - 1);
         3, 4: return coord_type'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Mostly in-range angles, sometimes values of a full turn and above.
   function automatic angle_type random_angle();
      if ($urandom_range(0, 7) == 0) begin
         return angle_type'($urandom_range(FULL_TURN, ANGLE_MAX));
      end
      return angle_type'($urandom_range(0, FULL_TURN - 1));
   endfunction

   task automatic check_field(input string name, input coord_type want, input coord_type got);
      if (got !== want) begin
         if (mismatches < PRINT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
         mismatches++;
      end
   endtask

   // Transaction monitor: register writes update the predictor, accepted vertices are
   // predicted, and each result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ANGLE_FIRST: begin
                  angle_z_deg = csr_wdata;
               end
               CSR_ANGLE_SECOND: begin
                  angle_y_deg = csr_wdata;
               end
               CSR_ANGLE_THIRD: begin
                  angle_x_deg = csr_wdata;
               end
               default: begin
               end
            endcase
            rebuild_matrix();
         end
         if (req_tvalid && req_tready) begin
            pending_rotations.push_back(rotate_vertex(point_t'(req_tdata[VERTEX_W-1:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_point = point_t'(rsp_tdata[VERTEX_W-1:0]);
            if (pending_rotations.size() == 0) begin
               if (mismatches < PRINT_LIMIT) begin
                  $display("%0t: unexpected result: expected none, actual %0d %0d %0d",
                           $time, got_point.x, got_point.y, got_point.z);
               end
               mismatches++;
            end else begin
               want_point = pending_rotations.pop_front();
               check_field("rot_x", want_point.x, got_point.x);
               check_field("rot_y", want_point.y, got_point.y);
               check_field("rot_z", want_point.z, got_point.z);
            end
         end
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready)
             || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: calm stretches alternate with stretches of random stall runs.
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (cycle_no[8:7] != 2'b00 && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: ends the run when no transaction happens for too long.
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Sends one vertex; the sender works in bursts separated by random gaps.
   task automatic send_vertex(input coord_type cx, input coord_type cy, input coord_type cz);
      int     gap;
      point_t p;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      p.x = cx;
      p.y = cy;
      p.z = cz;
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(p);
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Stops sending and waits until every predicted rotation has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Angle writes happen only with the pipeline empty.
   task automatic write_angle(input logic [CSR_INDEX_W-1:0] idx, input angle_type value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_angles(input angle_type az, input angle_type ay, input angle_type ax);
      write_angle(CSR_ANGLE_FIRST, az);
      write_angle(CSR_ANGLE_SECOND, ay);
      write_angle(CSR_ANGLE_THIRD, ax);
   endtask

   // The reset matrix is the identity, so coordinate extremes must pass unchanged.
   task automatic test_identity_extremes();
      send_vertex(0, 0, 0);
      send_vertex(COORD_MAX, COORD_MIN, -1);
      send_vertex(COORD_MIN, COORD_MAX, 1);
      send_vertex(1, -1, coord_type'(32'h0001_0000));
      send_vertex(coord_type'(32'h5555_5555), coord_type'(32'hAAAA_AAAA),
                  coord_type'(32'h0F0F_0F0F));
      send_vertex(coord_type'(32'hF0F0_F0F0), COORD_MAX, COORD_MAX);
   endtask

   // Saturation, quadrant boundaries, octant crossover, wrap of large angles and the
   // ignored register index.
   task automatic test_angle_special_cases();
      set_angles(45, 45, 45);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
      send_vertex(COORD_MAX, COORD_MIN, 0);
      set_angles(90, 180, 270);
      send_vertex(coord_type'(32'h0001_0000), coord_type'(32'h0002_0000), -3);
      send_vertex(COORD_MIN, 7, COORD_MAX);
      set_angles(46, 89, 359);
      send_vertex(coord_type'(32'h1234_5678), coord_type'(32'h8765_4321), 12345);
      send_vertex(COORD_MAX, -1, COORD_MIN);
      set_angles(FULL_TURN, ANGLE_MAX, 400);
      send_vertex(coord_type'(32'h0010_0000), coord_type'(32'hFFF0_0000), 99);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MIN);
      write_angle(CSR_UNUSED, ANGLE_MAX);
      send_vertex(coord_type'(32'h0003_0000), -77, coord_type'(32'h7FFF_0000));
      send_vertex(COORD_MIN, COORD_MIN, 1);
      set_angles(0, 0, 0);
      send_vertex(COORD_MAX, 0, COORD_MIN);
   endtask

   // The sender stops until the pipeline is empty, then resumes.
   task automatic test_drain_pause();
      int k;
      for (k = 0; k < 20; k++) begin
         send_vertex(random_coord(), random_coord(), random_coord());
      end
      wait_for_results();
      for (k = 0; k < 20; k++) begin
         send_vertex(random_coord(), random_coord(), random_coord());
      end
   endtask

   // Random vertices in phases, with random angle writes between the phases.
   task automatic test_random_rotations();
      int sent;
      int phase_len;
      int writes;
      int k;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         writes = $urandom_range(1, 3);
         for (k = 0; k < writes; k++) begin
            write_angle(CSR_INDEX_W'($urandom_range(CSR_ANGLE_FIRST, CSR_UNUSED)),
                        random_angle());
         end
         phase_len = $urandom_range(60, 140);
         for (k = 0; k < phase_len; k++) begin
            send_vertex(random_coord(), random_coord(), random_coord());
         end
         sent += phase_len;
      end
   endtask

   initial begin
      angle_z_deg = '0;
      angle_y_deg = '0;
      angle_x_deg = '0;
      rebuild_matrix();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_identity_extremes();
      test_angle_special_cases();
      test_drain_pause();
      test_random_rotations();
      wait_for_results();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (pending_rotations.size() != 0) begin
         $display("%0t: %0d results missing: expected 0 left, actual %0d left",
                  $time, pending_rotations.size(), pending_rotations.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
